[design/cbmt_pkg.sv]
// Package for the cosine best-match block: widths, constants, queue record and state type.
// Used by every module of the design; depends on nothing.
package cbmt_pkg;

  localparam int ACC_W      = 48;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] SIM_ONE   = 16'd32768;
  localparam logic [15:0] THR_RESET = 16'd19661;

  // One finished reference, handed from the accumulator to the similarity engine.
  typedef struct packed {
    logic [ACC_W-1:0] dot;
    logic [ACC_W-1:0] nq;
    logic [ACC_W-1:0] nr;
    logic [7:0]       id;
    logic             last_ref;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_ROOT_Q,
    ST_ROOT_U,
    ST_UPDATE,
    ST_EMIT
  } state_t;

endpackage

[design/cosine_best_match_threshold.sv]
// Cosine best match: takes one element pair per cycle while full is low; the products are
// registered in a product stage, then summed. The similarity engine handles each finished
// reference with a shared multiplier and a 15-step root search; a 4-deep queue holds
// finished references so the engine works on one while the front end sums the next.
// The result word is loaded after the last reference, once any earlier word is popped.
// Reset (rst_n low, synchronous) clears front sums and best state; threshold back to 19661.
module cosine_best_match_threshold (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_query_elem,
  input  logic signed [15:0] in_ref_elem,
  input  logic [7:0]         in_ref_id,
  input  logic               in_last_elem,
  input  logic               in_last_ref,
  output logic               empty,
  input  logic               pop,
  output logic               out_matched,
  output logic [7:0]         out_best_ref_id,
  output logic [15:0]        out_best_score,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  logic                            rec_push;
  cbmt_pkg::rec_t                  rec_wr;
  cbmt_pkg::rec_t                  rec_rd;
  logic                            rec_pop;
  logic                            rec_empty;
  logic [cbmt_pkg::FIFO_CNT_W-1:0] rec_count;

  // Accumulator front end.
  cbmt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_query_elem (in_query_elem),
    .in_ref_elem   (in_ref_elem),
    .in_ref_id     (in_ref_id),
    .in_last_elem  (in_last_elem),
    .in_last_ref   (in_last_ref),
    .fifo_count    (rec_count),
    .rec_push      (rec_push),
    .rec_data      (rec_wr)
  );

  // Record queue.
  cbmt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (rec_push),
    .wr_data  (rec_wr),
    .rd_en    (rec_pop),
    .rd_data  (rec_rd),
    .rd_empty (rec_empty),
    .count    (rec_count)
  );

  // Similarity engine and result word.
  cbmt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fifo_empty      (rec_empty),
    .fifo_data       (rec_rd),
    .fifo_pop        (rec_pop),
    .empty           (empty),
    .pop             (pop),
    .out_matched     (out_matched),
    .out_best_ref_id (out_best_ref_id),
    .out_best_score  (out_best_score)
  );

endmodule

[design/cbmt_front.sv]
// Front end: squares and products of each element pair, accumulated per reference.
// Depends on cbmt_pkg; pushes one record per finished reference into the queue.
module cbmt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic signed [15:0]             in_query_elem,
  input  logic signed [15:0]             in_ref_elem,
  input  logic [7:0]                     in_ref_id,
  input  logic                           in_last_elem,
  input  logic                           in_last_ref,
  input  logic [cbmt_pkg::FIFO_CNT_W-1:0] fifo_count,
  output logic                           rec_push,
  output cbmt_pkg::rec_t                 rec_data
);

  logic               s1_valid_r;
  logic signed [31:0] s1_dp_r;
  logic signed [31:0] s1_qq_r;
  logic signed [31:0] s1_rr_r;
  logic [7:0]         s1_id_r;
  logic               s1_end_r;
  logic               s1_last_r;
  logic               accept;

  logic [cbmt_pkg::ACC_W-1:0] dot_r, dot_nxt;
  logic [cbmt_pkg::ACC_W-1:0] nq_r, nq_nxt;
  logic [cbmt_pkg::ACC_W-1:0] nr_r, nr_nxt;

  // Hold off when the queue could not take the record of an ending word in flight.
  assign full   = ({1'b0, fifo_count} + {{cbmt_pkg::FIFO_CNT_W{1'b0}}, s1_end_r & s1_valid_r})
                  >= (cbmt_pkg::FIFO_CNT_W + 1)'(cbmt_pkg::FIFO_DEPTH);
  assign accept = push && !full;

  // Product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_end_r   <= 1'b0;
      s1_last_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        s1_dp_r   <= in_query_elem * in_ref_elem;
        s1_qq_r   <= in_query_elem * in_query_elem;
        s1_rr_r   <= in_ref_elem * in_ref_elem;
        s1_id_r   <= in_ref_id;
        s1_end_r  <= in_last_elem | in_last_ref;
        s1_last_r <= in_last_ref;
      end
    end
  end

  // Accumulate; wraps modulo the accumulator width.
  always_comb begin
    dot_nxt = dot_r + {{(cbmt_pkg::ACC_W-32){s1_dp_r[31]}}, s1_dp_r};
    nq_nxt  = nq_r + {{(cbmt_pkg::ACC_W-32){1'b0}}, s1_qq_r};
    nr_nxt  = nr_r + {{(cbmt_pkg::ACC_W-32){1'b0}}, s1_rr_r};
  end

  assign rec_push          = s1_valid_r && s1_end_r;
  assign rec_data.dot      = dot_nxt;
  assign rec_data.nq       = nq_nxt;
  assign rec_data.nr       = nr_nxt;
  assign rec_data.id       = s1_id_r;
  assign rec_data.last_ref = s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      nq_r  <= '0;
      nr_r  <= '0;
    end else if (s1_valid_r) begin
      if (s1_end_r) begin
        dot_r <= '0;
        nq_r  <= '0;
        nr_r  <= '0;
      end else begin
        dot_r <= dot_nxt;
        nq_r  <= nq_nxt;
        nr_r  <= nr_nxt;
      end
    end
  end

endmodule

[design/cbmt_fifo.sv]
// Short queue of finished reference records between the front and back ends.
// Depends on cbmt_pkg for the record type and depth.
module cbmt_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  cbmt_pkg::rec_t                  wr_data,
  input  logic                            rd_en,
  output cbmt_pkg::rec_t                  rd_data,
  output logic                            rd_empty,
  output logic [cbmt_pkg::FIFO_CNT_W-1:0] count
);

  cbmt_pkg::rec_t                  mem_r [cbmt_pkg::FIFO_DEPTH];
  logic [cbmt_pkg::FIFO_PTR_W-1:0] wr_ptr_r;
  logic [cbmt_pkg::FIFO_PTR_W-1:0] rd_ptr_r;
  logic [cbmt_pkg::FIFO_CNT_W-1:0] count_r;

  assign rd_data  = mem_r[rd_ptr_r];
  assign rd_empty = (count_r == '0);
  assign count    = count_r;

  // Storage is written without reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[design/cbmt_back.sv]
// Back end: exact similarity of each reference, best-match tracking and the result word.
// Depends on cbmt_pkg; one shared 24x24 multiplier and a bit-per-step square-root search.
module cbmt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  input  logic           fifo_empty,
  input  cbmt_pkg::rec_t fifo_data,
  output logic           fifo_pop,
  output logic           empty,
  input  logic           pop,
  output logic           out_matched,
  output logic [7:0]     out_best_ref_id,
  output logic [15:0]    out_best_score
);

  cbmt_pkg::state_t state_r, state_nxt;
  cbmt_pkg::rec_t   rec_r;

  logic [3:0]   cnt_r;
  logic [47:0]  prod_r;
  logic         prod_v_r;
  logic [2:0]   prod_sel_r;
  logic [95:0]  p_r;
  logic [95:0]  dd_r;
  logic [127:0] a_r, c_r, p2_r, q_r;
  logic [14:0]  s_r;
  logic [3:0]   k_r;
  logic [15:0]  sim_r;
  logic [15:0]  best_sim_r;
  logic [7:0]   best_id_r;
  logic         best_valid_r;
  logic [15:0]  thr_r;
  logic         out_valid_r;
  logic         out_matched_r;
  logic [7:0]   out_id_r;
  logic [15:0]  out_sim_r;

  logic [47:0]  a_op, b_op;
  logic [23:0]  a_half, b_half;
  logic [95:0]  prod_shift;
  logic [1:0]   shift_sel;
  logic         sim_zero, sim_clamp, q_fits;
  logic [127:0] ds;
  logic [127:0] c_sum;
  logic [14:0]  s_nxt;
  logic         out_load;
  logic         matched;

  // Operand selection for the shared multiplier: four partial products each of nq*nr, dot*dot.
  always_comb begin
    a_op   = cnt_r[2] ? rec_r.dot : rec_r.nq;
    b_op   = cnt_r[2] ? rec_r.dot : rec_r.nr;
    a_half = cnt_r[1] ? a_op[47:24] : a_op[23:0];
    b_half = cnt_r[0] ? b_op[47:24] : b_op[23:0];
  end

  // Place a registered partial product at its weight.
  always_comb begin
    shift_sel = {1'b0, prod_sel_r[1]} + {1'b0, prod_sel_r[0]};
    case (shift_sel)
      2'd0:    prod_shift = {48'd0, prod_r};
      2'd1:    prod_shift = {24'd0, prod_r, 24'd0};
      2'd2:    prod_shift = {prod_r, 48'd0};
      default: prod_shift = '0;
    endcase
  end

  // Special cases and the comparison of the root search.
  always_comb begin
    sim_zero  = (rec_r.nq == '0) || (rec_r.nr == '0) || (rec_r.dot == '0) || rec_r.dot[47];
    sim_clamp = (p_r <= dd_r);
    ds        = {2'b00, dd_r, 30'd0};
    q_fits    = (q_r <= ds);
    c_sum     = q_fits ? (c_r + {p2_r[126:0], 1'b0}) : c_r;
    s_nxt     = q_fits ? (s_r | (15'd1 << k_r)) : s_r;
    matched   = best_valid_r && (best_sim_r >= thr_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbmt_pkg::ST_IDLE:   if (!fifo_empty) state_nxt = cbmt_pkg::ST_MUL;
      cbmt_pkg::ST_MUL:    if (cnt_r == 4'd8) state_nxt = cbmt_pkg::ST_CHECK;
      cbmt_pkg::ST_CHECK: begin
        if (sim_zero || sim_clamp) state_nxt = cbmt_pkg::ST_UPDATE;
        else                       state_nxt = cbmt_pkg::ST_ROOT_Q;
      end
      cbmt_pkg::ST_ROOT_Q: state_nxt = cbmt_pkg::ST_ROOT_U;
      cbmt_pkg::ST_ROOT_U: begin
        if (k_r == 4'd0) state_nxt = cbmt_pkg::ST_UPDATE;
        else             state_nxt = cbmt_pkg::ST_ROOT_Q;
      end
      cbmt_pkg::ST_UPDATE: begin
        if (rec_r.last_ref) state_nxt = cbmt_pkg::ST_EMIT;
        else                state_nxt = cbmt_pkg::ST_IDLE;
      end
      cbmt_pkg::ST_EMIT:   if (out_load) state_nxt = cbmt_pkg::ST_IDLE;
      default:             state_nxt = cbmt_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    fifo_pop = 1'b0;
    out_load = 1'b0;
    case (state_r)
      cbmt_pkg::ST_IDLE: fifo_pop = !fifo_empty;
      cbmt_pkg::ST_EMIT: out_load = !out_valid_r || pop;
      default: begin
        fifo_pop = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cbmt_pkg::ST_IDLE;
      cnt_r        <= '0;
      prod_v_r     <= 1'b0;
      best_valid_r <= 1'b0;
      best_sim_r   <= '0;
      best_id_r    <= '0;
      thr_r        <= cbmt_pkg::THR_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (fifo_pop) begin
        cnt_r <= '0;
      end else if (state_r == cbmt_pkg::ST_MUL) begin
        cnt_r <= cnt_r + 1'b1;
      end
      prod_v_r <= (state_r == cbmt_pkg::ST_MUL) && (cnt_r < 4'd8);
      if (state_r == cbmt_pkg::ST_UPDATE && sim_r > best_sim_r) begin
        best_sim_r   <= sim_r;
        best_id_r    <= rec_r.id;
        best_valid_r <= 1'b1;
      end
      if (out_load) begin
        best_sim_r   <= '0;
        best_id_r    <= '0;
        best_valid_r <= 1'b0;
        out_valid_r  <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      rec_r <= fifo_data;
      p_r   <= '0;
      dd_r  <= '0;
    end
    if (state_r == cbmt_pkg::ST_MUL) begin
      prod_r     <= a_half * b_half;
      prod_sel_r <= cnt_r[2:0];
    end
    if (prod_v_r) begin
      if (prod_sel_r[2]) dd_r <= dd_r + prod_shift;
      else               p_r  <= p_r + prod_shift;
    end
    case (state_r)
      cbmt_pkg::ST_CHECK: begin
        a_r   <= '0;
        c_r   <= '0;
        p2_r  <= {4'd0, p_r, 28'd0};
        s_r   <= '0;
        k_r   <= 4'd14;
        sim_r <= sim_zero ? 16'd0 : cbmt_pkg::SIM_ONE;
      end
      cbmt_pkg::ST_ROOT_Q: q_r <= a_r + c_r + p2_r;
      cbmt_pkg::ST_ROOT_U: begin
        if (q_fits) a_r <= q_r;
        c_r   <= c_sum >> 1;
        p2_r  <= p2_r >> 2;
        s_r   <= s_nxt;
        k_r   <= k_r - 1'b1;
        sim_r <= {1'b0, s_nxt};
      end
      default: q_r <= q_r;
    endcase
    if (out_load) begin
      out_matched_r <= matched;
      out_id_r      <= matched ? best_id_r : 8'd0;
      out_sim_r     <= best_sim_r;
    end
  end

  assign empty           = !out_valid_r;
  assign out_matched     = out_matched_r;
  assign out_best_ref_id = out_id_r;
  assign out_best_score  = out_sim_r;

`ifndef SYNTH
  // A waiting result word is never dropped without a pop.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pop) |=> out_valid_r)
    else $error("result word lost while waiting");

  // The best similarity never exceeds one.
  a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
    best_sim_r <= cbmt_pkg::SIM_ONE)
    else $error("best similarity out of range");

  // A record is taken from the queue only when the engine is idle and the queue holds one.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> (state_r == cbmt_pkg::ST_IDLE) && !fifo_empty)
    else $error("queue popped while busy or empty");

  // A zero best similarity is never marked as a valid best.
  a_valid_pos: assert property (@(posedge clk) disable iff (!rst_n)
    best_valid_r |-> (best_sim_r != 16'd0))
    else $error("valid best with zero similarity");
`endif

endmodule
